[hw/rtl/lfu_pkg.sv]
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SIZE_W  = $clog2(ENTRIES + 1);
    localparam int TAG_W   = 32;
    localparam int SLOT_W  = 4;
    localparam int HIT_W   = 32;
    localparam int TS_W    = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 40;

    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
    localparam logic [HIT_W-1:0]      HIT_MAX  = {HIT_W{1'b1}};
    localparam logic [TS_W-1:0]       TABLE_SIZE_RESET = TS_W'(16);

    // Register index, decoded from paddr above the byte offset.
    localparam logic [CFG_ADDR_W-3:0] REG_TABLE_SIZE = '0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Carrier that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [COUNT_BITS-1:0] best_cnt;
        logic [IDX_W-1:0]      best_idx;
    } scan_t;

    // Update broadcast to all cells when a request completes.
    typedef struct packed {
        logic             en;
        logic             load;
        logic [IDX_W-1:0] slot;
        logic [TAG_W-1:0] tag;
    } upd_t;

endpackage

[hw/rtl/lfu_cell.sv]
module lfu_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lfu_pkg::IDX_W-1:0]  idx,
    input  logic [lfu_pkg::SIZE_W-1:0] size,
    input  logic [lfu_pkg::TAG_W-1:0]  page,
    input  lfu_pkg::scan_t             scan_in,
    output lfu_pkg::scan_t             scan_out,
    input  lfu_pkg::upd_t              upd
);
    import lfu_pkg::*;

    logic [TAG_W-1:0]      tag_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  valid_reg;
    scan_t                 scan_reg;
    scan_t                 scan_next;
    logic                  in_use;
    logic                  match;
    logic                  sel;

    assign in_use = SIZE_W'(idx) < size;
    assign match  = valid_reg && (tag_reg == page) && in_use;
    assign sel    = upd.en && (upd.slot == idx);

    always_comb
    begin
        scan_next = scan_in;
        if (in_use)
        begin
            if (!scan_in.hit && match)
            begin
                scan_next.hit     = 1'b1;
                scan_next.hit_idx = idx;
            end
            if (cnt_reg < scan_in.best_cnt)
            begin
                scan_next.best_cnt = cnt_reg;
                scan_next.best_idx = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && upd.load)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (sel)
        begin
            if (upd.load)
            begin
                tag_reg <= upd.tag;
                cnt_reg <= CNT_ONE;
            end
            else if (cnt_reg != CNT_MAX)
            begin
                cnt_reg <= cnt_reg + CNT_ONE;
            end
        end
    end

    assign scan_out = scan_reg;

endmodule

[hw/rtl/lfu_page_replacement.sv]
// Least-frequently-used page table.
// Requests arrive on the s_ side: s_tdata carries a 32-bit page number. Each
// request gives exactly one result on the m_ side: fault flag, slot index,
// eviction flag and the saturating running hit total.
// The lookup and the minimum-count search run along a row of 16 cells, the
// carrier moving one cell per clock. Once it has left the last cell the
// table is updated and the result registered, unless an earlier result is
// still waiting unaccepted in the output register. A new request is taken
// only after the previous one has updated the table.
// The result sits in an output register, so a new request is accepted while
// a previous result is still waiting; a stalled receiver only holds up the
// request behind it once that one has finished its scan.
// The APB port holds table_size at byte address 0; write it only while the
// block is idle. Reset empties the table, clears the hit total and sets
// table_size to 16. Tags and counts are not cleared: entries become valid as
// they are filled.
module lfu_page_replacement (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [31:0] page_number
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] fault, [4:1] slot, [5] evicted, [37:6] hit_total, [39:38] zero
    output logic [lfu_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lfu_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lfu_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lfu_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lfu_pkg::*;

    localparam int CMP_W = (SIZE_W > TS_W) ? SIZE_W : TS_W;
    localparam int SCAN_CNT_W = IDX_W;

    state_t                state_reg;
    state_t                state_next;
    logic [SCAN_CNT_W-1:0] cnt_reg;
    logic [SCAN_CNT_W-1:0] cnt_next;
    logic [TAG_W-1:0]      page_reg;
    logic [TS_W-1:0]       ts_reg;
    logic [SIZE_W-1:0]     fill_reg;
    logic [SIZE_W-1:0]     fill_next;
    logic [HIT_W-1:0]      hits_reg;
    logic [HIT_W-1:0]      hits_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_fault_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic                  out_evict_reg;

    logic                  accept;
    logic                  fire;
    logic                  cfg_wr;
    logic [CMP_W-1:0]      ts_ext;
    logic [SIZE_W-1:0]     eff_size;
    logic                  full;
    logic [IDX_W-1:0]      res_slot;
    logic                  res_evict;
    upd_t                  upd;
    scan_t                 scan_init;
    scan_t                 chain [ENTRIES+1];

    // Effective table size, clamped to 1..ENTRIES.
    assign ts_ext = CMP_W'(ts_reg);
    always_comb
    begin
        priority if (ts_reg == '0)
            eff_size = SIZE_W'(1);
        else if (ts_ext > CMP_W'(ENTRIES))
            eff_size = SIZE_W'(ENTRIES);
        else
            eff_size = SIZE_W'(ts_ext);
    end

    assign full = fill_reg >= eff_size;

    assign scan_init = '{hit: 1'b0, hit_idx: '0, best_cnt: CNT_MAX, best_idx: '0};
    assign chain[0]  = scan_init;

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        lfu_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (IDX_W'(k)),
            .size     (eff_size),
            .page     (page_reg),
            .scan_in  (chain[k]),
            .scan_out (chain[k+1]),
            .upd      (upd)
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cnt_reg == SCAN_CNT_W'(ENTRIES - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_tready = 1'b0;
        fire     = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SCAN: ;
            ST_DONE: fire = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
            cnt_next = '0;
        else if (state_reg == ST_SCAN)
            cnt_next = cnt_reg + SCAN_CNT_W'(1);
    end

    // Decision once the carrier has left the last cell.
    always_comb
    begin
        fill_next = fill_reg;
        hits_next = hits_reg;
        res_evict = 1'b0;
        upd.en    = fire;
        upd.tag   = page_reg;
        upd.load  = 1'b1;
        priority if (chain[ENTRIES].hit)
        begin
            res_slot = chain[ENTRIES].hit_idx;
            upd.load = 1'b0;
            if (hits_reg != HIT_MAX)
                hits_next = hits_reg + HIT_W'(1);
        end
        else if (!full)
        begin
            res_slot  = IDX_W'(fill_reg);
            fill_next = fill_reg + SIZE_W'(1);
        end
        else
        begin
            res_slot  = chain[ENTRIES].best_idx;
            res_evict = 1'b1;
        end
        upd.slot = res_slot;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ts_reg        <= TABLE_SIZE_RESET;
            fill_reg      <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                fill_reg <= fill_next;
                hits_reg <= hits_next;
            end
            if (cfg_wr && paddr[CFG_ADDR_W-1:2] == REG_TABLE_SIZE)
                ts_reg <= pwdata[TS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            page_reg <= s_tdata;
        if (fire)
        begin
            out_fault_reg <= !chain[ENTRIES].hit;
            out_slot_reg  <= SLOT_W'(res_slot);
            out_evict_reg <= res_evict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, hits_reg, out_evict_reg, out_slot_reg, out_fault_reg};

    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_TABLE_SIZE)
                    ? CFG_DATA_W'(ts_reg) : '0;

endmodule

[bench/tb_lfu_page_replacement.sv]
module tb_lfu_page_replacement;

    import lfu_pkg::*;

    typedef struct packed {
        logic [HIT_W-1:0]  hit_total;
        logic              evicted;
        logic [SLOT_W-1:0] slot;
        logic              fault;
    } lfu_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;    // [31:0] page_number
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] fault, [4:1] slot, [5] evicted, [37:6] hit_total, [39:38] zero
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    lfu_page_replacement u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the page table.
    logic [TAG_W-1:0]      tag_store [ENTRIES];
    logic [COUNT_BITS-1:0] use_count [ENTRIES];
    logic                  tag_valid [ENTRIES];
    int unsigned           filled = 0;
    logic [HIT_W-1:0]      hit_count = '0;
    logic [TS_W-1:0]       size_cfg = TABLE_SIZE_RESET;

    logic [31:0]  request_queue [$];
    lfu_result_t  expected_results [$];
    logic [31:0]  page_pool [$];
    logic [31:0]  next_page;
    int unsigned  send_idle = 0;
    int unsigned  recv_idle = 0;
    int unsigned  error_count = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned effective_size();
        if (size_cfg == 0)
            return 1;
        if (size_cfg > ENTRIES)
            return ENTRIES;
        return int'(size_cfg);
    endfunction

    function automatic lfu_result_t predict_lookup(input logic [31:0] page);
        int unsigned eff;
        int unsigned pick;
        logic        found;
        lfu_result_t res;
        eff   = effective_size();
        found = 1'b0;
        pick  = 0;
        res   = '0;
        for (int unsigned i = 0; i < eff; i++)
            if (!found && tag_valid[i] && tag_store[i] == page)
            begin
                found = 1'b1;
                pick  = i;
            end
        if (found)
        begin
            if (use_count[pick] != CNT_MAX)
                use_count[pick] = use_count[pick] + CNT_ONE;
            if (hit_count != HIT_MAX)
                hit_count = hit_count + HIT_W'(1);
        end
        else
        begin
            if (filled < eff)
            begin
                pick   = filled;
                filled = filled + 1;
            end
            else
            begin
                // Smallest count wins; a strict compare keeps the lowest index on a tie.
                pick = 0;
                for (int unsigned i = 1; i < eff; i++)
                    if (use_count[i] < use_count[pick])
                        pick = i;
                res.evicted = 1'b1;
            end
            tag_store[pick] = page;
            use_count[pick] = CNT_ONE;
            tag_valid[pick] = 1'b1;
        end
        res.fault     = !found;
        res.slot      = pick[SLOT_W-1:0];
        res.hit_total = hit_count;
        return res;
    endfunction

    // Request driver.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_lookup(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    next_page = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_page;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        lfu_result_t want;
        lfu_result_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = lfu_result_t'(m_tdata[$bits(lfu_result_t)-1:0]);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, expected none, got %h",
                             $time, got);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.fault !== want.fault)
                    begin
                        $display("%0t: fault expected %0d got %0d", $time, want.fault, got.fault);
                        error_count++;
                    end
                    if (got.slot !== want.slot)
                    begin
                        $display("%0t: slot expected %0d got %0d", $time, want.slot, got.slot);
                        error_count++;
                    end
                    if (got.evicted !== want.evicted)
                    begin
                        $display("%0t: evicted expected %0d got %0d",
                                 $time, want.evicted, got.evicted);
                        error_count++;
                    end
                    if (got.hit_total !== want.hit_total)
                    begin
                        $display("%0t: hit_total expected %0d got %0d",
                                 $time, want.hit_total, got.hit_total);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic write_table_size(input logic [TS_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TABLE_SIZE, 2'b00};
        // Bits above the register width are don't-care and are scrambled.
        pwdata  <= ($urandom() & 32'hFFFF_FFE0) | 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        size_cfg  = value;
    endtask

    // Waits until every request has gone through and its result has been checked,
    // then lets the block settle before the next register write.
    task automatic wait_until_quiet();
        while (request_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_page();
        int unsigned roll;
        logic [31:0] corner [4];
        corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        roll   = $urandom_range(0, 99);
        if (roll < 10)
            return $urandom;
        if (roll < 15)
            return corner[$urandom_range(0, 3)];
        // Skewed towards the front of the pool so that use counts drift apart.
        return page_pool[$urandom_range(0, $urandom_range(0, page_pool.size() - 1))];
    endfunction

    initial
    begin
        logic [TS_W-1:0] phase_size [8];
        int unsigned     pool_len;
        phase_size = '{5'd3, 5'd16, 5'd1, 5'd8, 5'd0, 5'd31, 5'd2, 5'd12};
        for (int i = 0; i < ENTRIES; i++)
            tag_valid[i] = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 21;
        recv_idle = 69;

        // Reset size: fill a few slots with the extreme page numbers and hit them.
        request_queue = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};
        wait_until_quiet();

        // Shrink below the fill level: the table is full and upper slots are ignored.
        write_table_size(5'd2);
        request_queue = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h1234_5678,
                          32'hA5A5_A5A5};
        wait_until_quiet();

        // A size of zero behaves as a single slot.
        write_table_size(5'd0);
        request_queue = '{32'h0000_0007, 32'h0000_0007, 32'hFFFF_FFFF};
        wait_until_quiet();

        // Oversized value clamps to the full table; hidden slots come back into view.
        write_table_size(5'd31);
        request_queue = '{32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0002,
                          32'h7FFF_FFFF};
        wait_until_quiet();

        for (int p = 0; p < 8; p++)
        begin
            if (p < 3)
            begin
                send_idle = 21;
                recv_idle = 69;
            end
            else if (p < 6)
            begin
                send_idle = 69;
                recv_idle = 21;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_table_size(phase_size[p]);
            pool_len = effective_size() + $urandom_range(1, effective_size() + 2);
            page_pool.delete();
            for (int k = 0; k < pool_len; k++)
                page_pool.push_back($urandom);
            for (int k = 0; k < 88; k++)
                request_queue.push_back(pick_page());
            wait_until_quiet();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[lfu_page_replacement.f]
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_cell.sv
hw/rtl/lfu_page_replacement.sv
bench/tb_lfu_page_replacement.sv
